[hdl/chm_pkg.sv]
// ----------------------------------------------------------------------------
// Core heartbeat monitor package
// Types, codes and reset values shared by the heartbeat monitor modules.
// ----------------------------------------------------------------------------
package chm_pkg;

	localparam int unsigned TIMEOUT_W = 16;
	localparam int unsigned WAIT_W    = 16;
	localparam int unsigned TRIES_W   = 4;
	localparam int unsigned WINDOW_W  = WAIT_W + TRIES_W;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned ID_W      = 3;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(6000);
	localparam logic [WAIT_W-1:0]    WAIT_RST    = WAIT_W'(2000);
	localparam logic [TRIES_W-1:0]   TRIES_RST   = TRIES_W'(5);

	typedef enum logic [2:0] {
		ACT_TICK    = 3'd0,
		ACT_RESET   = 3'd1,
		ACT_BEAT    = 3'd2,
		ACT_PWRUP   = 3'd3,
		ACT_DUMP    = 3'd4,
		ACT_LVEXIT  = 3'd5,
		ACT_QUERY   = 3'd6
	} chm_action_t;

	typedef enum logic [1:0] {
		LINK_OFF      = 2'd0,
		LINK_STARTING = 2'd1,
		LINK_ON       = 2'd2
	} chm_link_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT    = 8'd0,
		CFG_START_WAIT = 8'd1,
		CFG_START_TRY  = 8'd2,
		CFG_BEAT_START = 8'd3
	} chm_cfg_idx_t;

	typedef struct packed {
		logic [2:0]        action;
		logic [ID_W-1:0]   cpu_id;
		logic              flag;
		logic [TIME_W-1:0] now_ms;
		logic              sleep_seen;
	} chm_item_t;

	typedef struct packed {
		logic [1:0] link_state_out;
		logic       timed_out_out;
		logic       id_rejected;
		logic       is_on;
		logic       is_off;
		logic       clear_sleep;
	} chm_result_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] timeout_ms;
		logic [WINDOW_W-1:0]  window_ms;
		logic                 beat_completes_start;
	} chm_cfg_t;

endpackage

[hdl/chm_if.sv]
// ----------------------------------------------------------------------------
// Core heartbeat monitor channels
// Event, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface chm_evt_if;
	logic                             valid;
	logic                             ready;
	logic [2:0]                       action;
	logic [chm_pkg::ID_W-1:0]         cpu_id;
	logic                             flag;
	logic [chm_pkg::TIME_W-1:0]       now_ms;
	logic                             sleep_seen;

	modport source (output valid, action, cpu_id, flag, now_ms, sleep_seen, input ready);
	modport sink (input valid, action, cpu_id, flag, now_ms, sleep_seen, output ready);
endinterface

interface chm_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] link_state_out;
	logic       timed_out_out;
	logic       id_rejected;
	logic       is_on;
	logic       is_off;
	logic       clear_sleep;

	modport source (output valid, link_state_out, timed_out_out, id_rejected, is_on, is_off,
		clear_sleep, input ready);
	modport sink (input valid, link_state_out, timed_out_out, id_rejected, is_on, is_off,
		clear_sleep, output ready);
endinterface

interface chm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [chm_pkg::CFG_IDX_W-1:0]   index;
	logic [chm_pkg::CFG_DAT_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/chm_engine.sv]
// ----------------------------------------------------------------------------
// Core heartbeat monitor engine
// Holds the supervision state and applies one event item per step.
// ----------------------------------------------------------------------------
module chm_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  chm_pkg::chm_item_t  item,
	input  chm_pkg::chm_cfg_t   cfg,
	output chm_pkg::chm_result_t result
);

	chm_pkg::chm_link_t                link_q;
	logic [chm_pkg::ID_W-1:0]          bound_id_q;
	logic                              id_bound_q;
	logic [chm_pkg::TIME_W-1:0]        last_beat_q;
	logic [chm_pkg::TIME_W-1:0]        last_event_q;
	logic                              dump_q;
	logic                              lv_exit_q;
	logic                              pending_q;
	logic [chm_pkg::TIME_W-1:0]        start_begin_q;
	logic                              timed_out_q;

	chm_pkg::chm_link_t                link_d;
	logic [chm_pkg::ID_W-1:0]          bound_id_d;
	logic                              id_bound_d;
	logic [chm_pkg::TIME_W-1:0]        last_beat_d;
	logic [chm_pkg::TIME_W-1:0]        last_event_d;
	logic                              dump_d;
	logic                              lv_exit_d;
	logic                              pending_d;
	logic [chm_pkg::TIME_W-1:0]        start_begin_d;
	logic                              timed_out_d;
	logic                              rejected;
	logic                              clear_d;
	logic                              id_ok;
	logic                              do_try;
	logic                              do_check;
	logic                              mine;
	logic [chm_pkg::TIME_W-1:0]        now;
	logic [chm_pkg::TIME_W-1:0]        window_ext;
	logic [chm_pkg::TIME_W-1:0]        timeout_ext;

	assign now         = item.now_ms;
	assign window_ext  = chm_pkg::TIME_W'(cfg.window_ms);
	assign timeout_ext = chm_pkg::TIME_W'(cfg.timeout_ms);

	always_comb begin
		link_d        = link_q;
		bound_id_d    = bound_id_q;
		id_bound_d    = id_bound_q;
		last_beat_d   = last_beat_q;
		last_event_d  = last_event_q;
		dump_d        = dump_q;
		lv_exit_d     = lv_exit_q;
		pending_d     = pending_q;
		start_begin_d = start_begin_q;
		timed_out_d   = timed_out_q;
		rejected      = 1'b0;
		clear_d       = 1'b0;
		do_try        = 1'b0;
		do_check      = 1'b0;

		// Events that carry an id bind the first one seen.
		id_ok = !id_bound_q || (bound_id_q == item.cpu_id);
		case (chm_pkg::chm_action_t'(item.action))
			chm_pkg::ACT_RESET, chm_pkg::ACT_BEAT, chm_pkg::ACT_PWRUP,
			chm_pkg::ACT_DUMP: begin
				if (!id_bound_q) begin
					id_bound_d = 1'b1;
					bound_id_d = item.cpu_id;
				end
				rejected = !id_ok;
			end
			default: begin
			end
		endcase

		case (chm_pkg::chm_action_t'(item.action))
			chm_pkg::ACT_TICK: begin
				if (pending_q) begin
					if ((now - start_begin_q) >= window_ext) begin
						pending_d    = 1'b0;
						last_event_d = now;
					end
				end else if (link_q != chm_pkg::LINK_OFF &&
						(now - last_event_q) >= timeout_ext) begin
					do_check     = 1'b1;
					last_event_d = now;
				end
			end
			chm_pkg::ACT_RESET: begin
				if (id_ok) begin
					last_event_d = now;
					if (item.flag) begin
						if (link_q != chm_pkg::LINK_ON) begin
							link_d        = chm_pkg::LINK_STARTING;
							pending_d     = 1'b1;
							start_begin_d = now;
							last_beat_d   = now;
						end
					end else begin
						link_d    = chm_pkg::LINK_OFF;
						pending_d = 1'b0;
					end
				end
			end
			chm_pkg::ACT_BEAT: begin
				if (id_ok) begin
					last_event_d = now;
					do_try       = cfg.beat_completes_start;
					do_check     = 1'b1;
				end
			end
			chm_pkg::ACT_PWRUP: begin
				if (id_ok) begin
					last_event_d = now;
					if (link_q == chm_pkg::LINK_OFF) begin
						link_d        = chm_pkg::LINK_STARTING;
						pending_d     = 1'b1;
						start_begin_d = now;
						last_beat_d   = now;
					end
					do_try = 1'b1;
				end
			end
			chm_pkg::ACT_DUMP: begin
				if (id_ok) begin
					dump_d = item.flag;
				end
			end
			chm_pkg::ACT_LVEXIT: begin
				last_beat_d = now;
				lv_exit_d   = 1'b1;
			end
			default: begin
			end
		endcase

		// A power-up or enabled beat inside the start window completes the start.
		if (do_try && link_d == chm_pkg::LINK_STARTING && pending_d &&
				(now - start_begin_d) < window_ext) begin
			link_d      = chm_pkg::LINK_ON;
			pending_d   = 1'b0;
			last_beat_d = now;
		end

		// The heartbeat check: every case but a timeout refreshes the beat time.
		if (do_check && link_d != chm_pkg::LINK_OFF) begin
			if (link_d == chm_pkg::LINK_STARTING || dump_d) begin
				last_beat_d = now;
			end else if ((now - last_beat_d) < timeout_ext) begin
				last_beat_d = now;
			end else if (item.sleep_seen) begin
				last_beat_d = now;
				clear_d     = 1'b1;
			end else if (lv_exit_d) begin
				last_beat_d = now;
				lv_exit_d   = 1'b0;
			end else begin
				timed_out_d = 1'b1;
			end
		end

		mine = id_bound_d && (bound_id_d == item.cpu_id);
		result.link_state_out = link_d;
		result.timed_out_out  = timed_out_d;
		result.id_rejected    = rejected;
		result.is_on          = mine && link_d == chm_pkg::LINK_ON;
		result.is_off         = !mine || link_d == chm_pkg::LINK_OFF;
		result.clear_sleep    = clear_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q        <= chm_pkg::LINK_OFF;
			bound_id_q    <= '0;
			id_bound_q    <= 1'b0;
			last_beat_q   <= '0;
			last_event_q  <= '0;
			dump_q        <= 1'b0;
			lv_exit_q     <= 1'b0;
			pending_q     <= 1'b0;
			start_begin_q <= '0;
			timed_out_q   <= 1'b0;
		end else if (step) begin
			link_q        <= link_d;
			bound_id_q    <= bound_id_d;
			id_bound_q    <= id_bound_d;
			last_beat_q   <= last_beat_d;
			last_event_q  <= last_event_d;
			dump_q        <= dump_d;
			lv_exit_q     <= lv_exit_d;
			pending_q     <= pending_d;
			start_begin_q <= start_begin_d;
			timed_out_q   <= timed_out_d;
		end
	end

	// The timeout is fatal and never clears until reset.
	a_timeout_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		timed_out_q |=> timed_out_q)
		else $error("heartbeat timeout cleared");

	// Once bound, the id never changes.
	a_id_held: assert property (@(posedge clk) disable iff (!arst_n)
		id_bound_q |=> id_bound_q && $stable(bound_id_q))
		else $error("bound core id changed");

	// An open start window only exists while the link is starting.
	a_pending_starting: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> link_q == chm_pkg::LINK_STARTING)
		else $error("start pending outside starting state");

	// A rejected event leaves the link untouched.
	a_reject_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		step && rejected |=> link_q == $past(link_q) && pending_q == $past(pending_q))
		else $error("rejected event changed the link");

	// A sleep clear request only comes from a check on a live link.
	a_clear_on: assert property (@(posedge clk) disable iff (!arst_n)
		step && clear_d |-> link_d == chm_pkg::LINK_ON)
		else $error("sleep clear outside on state");

endmodule

[hdl/core_heartbeat_monitor_top.sv]
// ----------------------------------------------------------------------------
// Core heartbeat monitor
// Supervises one secondary core from reset, power-up and heartbeat events.
// ----------------------------------------------------------------------------
// Usage:
//   Event items enter on evt; each gives exactly one result item on res.
//   An item is taken into an input register and, once the output register
//   is free or being read, applied to the supervision state at the edge
//   where its result is loaded into the output register, which drives res.
//   One item is accepted every cycle unless res stalls: the state update is
//   a single pass of compares and 32-bit subtractions, so the next item sees
//   it directly. When res is stalled the output register holds, the input
//   register still takes one more item, and evt.ready then falls until res
//   drains. cfg writes are always taken and apply to the next item that is
//   processed; the start window is the product of tries and wait time.
//   Writes must be made while the block is idle; it does not enforce this.
//   Reset (arst_n low) returns the link to off with no id bound, clears the
//   timeout and loads the register defaults 6000, 2000, 5 and 0.
// ----------------------------------------------------------------------------
module core_heartbeat_monitor_top (
	input  logic        clk,
	input  logic        arst_n,
	chm_evt_if.sink     evt,
	chm_res_if.source   res,
	chm_cfg_if.sink     cfg
);

	logic                              s1_valid_q;
	chm_pkg::chm_item_t                item_s1;
	logic                              res_valid_q;
	chm_pkg::chm_result_t              res_q;
	chm_pkg::chm_result_t              result;
	logic                              advance;
	logic [chm_pkg::TIMEOUT_W-1:0]     timeout_q;
	logic [chm_pkg::WAIT_W-1:0]        wait_q;
	logic [chm_pkg::TRIES_W-1:0]       tries_q;
	logic                              beat_start_q;
	chm_pkg::chm_cfg_t                 cfg_bus;

	assign advance   = s1_valid_q && (!res_valid_q || res.ready);
	assign evt.ready = !s1_valid_q || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (evt.ready) begin
			s1_valid_q <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			item_s1.action     <= evt.action;
			item_s1.cpu_id     <= evt.cpu_id;
			item_s1.flag       <= evt.flag;
			item_s1.now_ms     <= evt.now_ms;
			item_s1.sleep_seen <= evt.sleep_seen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= chm_pkg::TIMEOUT_RST;
			wait_q       <= chm_pkg::WAIT_RST;
			tries_q      <= chm_pkg::TRIES_RST;
			beat_start_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (chm_pkg::chm_cfg_idx_t'(cfg.index))
					chm_pkg::CFG_TIMEOUT:    timeout_q    <= cfg.data[chm_pkg::TIMEOUT_W-1:0];
					chm_pkg::CFG_START_WAIT: wait_q       <= cfg.data[chm_pkg::WAIT_W-1:0];
					chm_pkg::CFG_START_TRY:  tries_q      <= cfg.data[chm_pkg::TRIES_W-1:0];
					chm_pkg::CFG_BEAT_START: beat_start_q <= cfg.data[0];
					default: begin
					end
				endcase
			end
		end
	end

	assign cfg_bus.timeout_ms           = timeout_q;
	assign cfg_bus.window_ms            = chm_pkg::WINDOW_W'(tries_q) *
		chm_pkg::WINDOW_W'(wait_q);
	assign cfg_bus.beat_completes_start = beat_start_q;

	chm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_bus),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || res.ready) begin
			res_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.link_state_out = res_q.link_state_out;
	assign res.timed_out_out  = res_q.timed_out_out;
	assign res.id_rejected    = res_q.id_rejected;
	assign res.is_on          = res_q.is_on;
	assign res.is_off         = res_q.is_off;
	assign res.clear_sleep    = res_q.clear_sleep;

endmodule
